@@ rtl/acpd_pkg.sv @@
// Shared constants and types for the ambient-cancelling proximity detector.
package acpd_pkg;

  localparam int WINDOW_LEN = 8;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 12;
  localparam int PTR_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int COUNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W    = SAMPLE_W + PTR_W;
  localparam int DIFF_W   = SUM_W + 1;

  localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(WINDOW_LEN - 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WINDOW_LEN);
  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(WINDOW_LEN - 1);

  localparam logic signed [DIFF_W-1:0] DIFF_HI = DIFF_W'(2 ** (LEVEL_W - 1) - 1);
  localparam logic signed [DIFF_W-1:0] DIFF_LO = -DIFF_HI - DIFF_W'(1);

  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RESET = LEVEL_W'(100);

  typedef struct packed {
    logic             step;
    logic             priming;
    logic             prime_last;
    logic [PTR_W-1:0] slot;
  } lane_ctrl_t;

endpackage

@@ rtl/acpd_lane.sv @@
// One averaging lane: a sample ring and its running average.
module acpd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  acpd_pkg::lane_ctrl_t          ctrl,
  input  logic [acpd_pkg::SAMPLE_W-1:0] sample,
  output logic [acpd_pkg::SUM_W-1:0]    avg_next
);

  logic [acpd_pkg::SAMPLE_W-1:0] ring [acpd_pkg::WINDOW_LEN];
  logic [acpd_pkg::SUM_W-1:0]    avg;
  logic [acpd_pkg::SAMPLE_W-1:0] old_sample;
  logic [acpd_pkg::SUM_W-1:0]    sum_next;
  logic [acpd_pkg::SUM_W-1:0]    old_part;
  logic [acpd_pkg::SUM_W-1:0]    new_part;

  assign old_sample = ring[ctrl.slot];
  assign sum_next   = avg + acpd_pkg::SUM_W'(sample);
  assign old_part   = acpd_pkg::SUM_W'(old_sample / acpd_pkg::WINDOW_LEN);
  assign new_part   = acpd_pkg::SUM_W'(sample / acpd_pkg::WINDOW_LEN);

  always_comb begin
    if (ctrl.prime_last) begin
      avg_next = acpd_pkg::SUM_W'(sum_next / acpd_pkg::WINDOW_LEN);
    end else if (ctrl.priming) begin
      avg_next = sum_next;
    end else begin
      avg_next = avg - old_part + new_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctrl.step) begin
      avg <= avg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      ring[ctrl.slot] <= sample;
    end
  end

endmodule

@@ rtl/acpd_merge.sv @@
// Merge stage: lane difference, saturation, threshold compare and result register.
module acpd_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic [acpd_pkg::SUM_W-1:0]          ambient_avg,
  input  logic [acpd_pkg::SUM_W-1:0]          lit_avg,
  input  logic signed [acpd_pkg::LEVEL_W-1:0] threshold,
  input  logic                                result_ready,
  output logic                                result_valid,
  output logic signed [acpd_pkg::LEVEL_W-1:0] reflected_level,
  output logic                                obstacle_near
);

  logic signed [acpd_pkg::DIFF_W-1:0]  diff;
  logic signed [acpd_pkg::LEVEL_W-1:0] level_next;

  assign diff = $signed({1'b0, lit_avg}) - $signed({1'b0, ambient_avg});

  always_comb begin
    if (diff > acpd_pkg::DIFF_HI) begin
      level_next = acpd_pkg::DIFF_HI[acpd_pkg::LEVEL_W-1:0];
    end else if (diff < acpd_pkg::DIFF_LO) begin
      level_next = acpd_pkg::DIFF_LO[acpd_pkg::LEVEL_W-1:0];
    end else begin
      level_next = diff[acpd_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reflected_level <= level_next;
      obstacle_near   <= (level_next > threshold);
    end
  end

endmodule

@@ rtl/ambient_cancel_proximity_detect_top.sv @@
// Top level of the ambient-cancelling proximity detector.
//
//   Channel      Handshake                    Payload
//   sample       sample_valid/sample_ready    ambient_sample, lit_sample
//   result       result_valid/result_ready    reflected_level, obstacle_near
//   threshold    near_threshold_we            near_threshold
//
// One sample pair is taken every cycle while sample_ready is high; its result
// reaches the output register in the next cycle from each lane's running average.
// The first WINDOW_LEN pairs after reset only prime the rings and give no result.
// Reset is synchronous, clears the averages and counters and sets the threshold to 100.
// A stalled result holds the output register and blocks new pairs only while full.
module ambient_cancel_proximity_detect_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic [acpd_pkg::SAMPLE_W-1:0]       ambient_sample,
  input  logic [acpd_pkg::SAMPLE_W-1:0]       lit_sample,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [acpd_pkg::LEVEL_W-1:0] reflected_level,
  output logic                                obstacle_near,
  input  logic                                near_threshold_we,
  input  logic signed [acpd_pkg::LEVEL_W-1:0] near_threshold
);

  logic signed [acpd_pkg::LEVEL_W-1:0] threshold;
  logic [acpd_pkg::PTR_W-1:0]          ring_pointer;
  logic [acpd_pkg::COUNT_W-1:0]        prime_count;
  logic                                step;
  acpd_pkg::lane_ctrl_t                ctrl;
  logic [acpd_pkg::SUM_W-1:0]          ambient_avg;
  logic [acpd_pkg::SUM_W-1:0]          lit_avg;

  assign sample_ready = !result_valid || result_ready;
  assign step         = sample_valid && sample_ready;

  assign ctrl.step       = step;
  assign ctrl.priming    = (prime_count != acpd_pkg::COUNT_FULL);
  assign ctrl.prime_last = (prime_count == acpd_pkg::COUNT_LAST);
  assign ctrl.slot       = ring_pointer;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= acpd_pkg::THRESHOLD_RESET;
    end else if (near_threshold_we) begin
      threshold <= near_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer <= '0;
      prime_count  <= '0;
    end else if (step) begin
      if (ring_pointer == acpd_pkg::PTR_LAST) begin
        ring_pointer <= '0;
      end else begin
        ring_pointer <= ring_pointer + acpd_pkg::PTR_W'(1);
      end
      if (ctrl.priming) begin
        prime_count <= prime_count + acpd_pkg::COUNT_W'(1);
      end
    end
  end

  acpd_lane u_ambient_lane (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (ambient_sample),
    .avg_next (ambient_avg)
  );

  acpd_lane u_lit_lane (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .sample   (lit_sample),
    .avg_next (lit_avg)
  );

  acpd_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .load            (step && !ctrl.priming),
    .ambient_avg     (ambient_avg),
    .lit_avg         (lit_avg),
    .threshold       (threshold),
    .result_ready    (result_ready),
    .result_valid    (result_valid),
    .reflected_level (reflected_level),
    .obstacle_near   (obstacle_near)
  );

endmodule
